FILE: src/random_early_detection_top_assert.svh
// Assertion macros for the RED block. Each macro samples on the rising edge
// of clk and is switched off while rst_n is low.
`ifndef RANDOM_EARLY_DETECTION_TOP_ASSERT_SVH
`define RANDOM_EARLY_DETECTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("RED assertion failed");
`define RED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("RED assertion failed");
`else
`define RED_ASSERT_IMPL(lbl, ante, cons)
`define RED_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/red_pkg.sv
package red_pkg;

  localparam int LEN_W      = 16;
  localparam int AVG_W      = 24;
  localparam int CNT_W      = 16;
  localparam int PROB_W     = 7;
  localparam int WGT_W      = 9;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 32;
  localparam int MCAND_W    = 24;
  localparam int MPLIER_W   = 16;
  localparam int NBITS_W    = 5;
  localparam int QUOT_W     = 32;
  localparam int DEN_W      = 16;
  localparam int DIV_CNT_W  = 6;

  // Probability scale: 512 steps per percent, 100 percent.
  localparam logic [LEN_W-1:0] PROB_FULL = 16'd51200;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  localparam logic [LEN_W-1:0]  THR_LOW_RST  = 16'd0;
  localparam logic [LEN_W-1:0]  THR_HIGH_RST = 16'd1;
  localparam logic [PROB_W-1:0] PROB_RST     = 7'd1;
  localparam logic [WGT_W-1:0]  WGT_RST      = 9'd256;

  typedef enum logic [1:0] {
    REG_THR_LOW    = 2'd0,
    REG_THR_HIGH   = 2'd1,
    REG_DROP_PROB  = 2'd2,
    REG_AVG_WEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                go;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
    logic [NBITS_W-1:0]  nbits;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              go;
    logic [QUOT_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic              half;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/red_if.sv
interface red_in_if;
  import red_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [LEN_W-1:0] sample_len;
  logic [LEN_W-1:0] random_value;

  modport source(output valid, command, sample_len, random_value, input ready);
  modport sink(input valid, command, sample_len, random_value, output ready);
endinterface

interface red_out_if;
  import red_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] average_len;
  logic             drop;

  modport source(output valid, average_len, drop, input ready);
  modport sink(input valid, average_len, drop, output ready);
endinterface

FILE: src/random_early_detection_top.sv
// Random early detection (RED) queue manager.
// The input channel in_ch carries one transaction per command: an update
// folds sample_len into the running queue average, a check decides whether
// a packet is dropped, using random_value as the dice roll. Every input
// transaction produces exactly one output transaction on out_ch with the
// integer average and the drop flag (always zero for an update).
// Thresholds, maximum drop probability and averaging weight sit in four
// registers on the APB port at byte addresses 0, 4, 8 and 12.
// Items are handled one at a time. A direct load or a check outside the
// thresholds needs no arithmetic pass; a weighted update takes multiplier
// passes of 9 and 8 bits, and a check between the thresholds takes
// multiplier passes of 7 and 16 bits and divider passes of 16 and 32 bits,
// or stops after the second multiplier pass when the undropped count alone
// forces the drop. The next item can be accepted in the cycle after the
// output register is loaded.
// Reset (synchronous, active low) clears the average and the undropped
// count and loads the register defaults. The result sits in an output
// register, so a stalled receiver does not stop the block from accepting
// the next item; that item waits for the output register to free up.
module random_early_detection_top (
  input  logic                            clk,
  input  logic                            rst_n,
  red_in_if.sink                          in_ch,
  red_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [red_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [red_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [red_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import red_pkg::*;

  // The sequencer walks through the multiplier and divider passes of each
  // command; every wait state holds until the unit reports done.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_UPD_M1 = 9'b000000100,
    S_UPD_M2 = 9'b000001000,
    S_CHK_M1 = 9'b000010000,
    S_CHK_D1 = 9'b000100000,
    S_CHK_M2 = 9'b001000000,
    S_CHK_D2 = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [LEN_W-1:0]  thr_low_r;
  logic [LEN_W-1:0]  thr_high_r;
  logic [PROB_W-1:0] drop_prob_r;
  logic [WGT_W-1:0]  avg_weight_r;

  // Architectural state.
  logic [AVG_W-1:0] avg_r, avg_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Latched item and working values.
  logic             cmd_r, cmd_nxt;
  logic [LEN_W-1:0] sample_r, sample_nxt;
  logic [LEN_W-1:0] rnd_r, rnd_nxt;
  logic [AVG_W-1:0] part_r, part_nxt;
  logic [LEN_W-1:0] t_r, t_nxt;
  logic             drop_r, drop_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_avg_r, out_avg_nxt;
  logic             out_drop_r, out_drop_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic cfg_wr;

  red_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  red_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration port. Writes complete in the access cycle; reads are
  // served from the same register set.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r    <= THR_LOW_RST;
      thr_high_r   <= THR_HIGH_RST;
      drop_prob_r  <= PROB_RST;
      avg_weight_r <= WGT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_THR_LOW:    thr_low_r    <= pwdata[LEN_W-1:0];
        REG_THR_HIGH:   thr_high_r   <= pwdata[LEN_W-1:0];
        REG_DROP_PROB:  drop_prob_r  <= pwdata[PROB_W-1:0];
        REG_AVG_WEIGHT: avg_weight_r <= pwdata[WGT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_THR_LOW:    prdata = CFG_DATA_W'(thr_low_r);
      REG_THR_HIGH:   prdata = CFG_DATA_W'(thr_high_r);
      REG_DROP_PROB:  prdata = CFG_DATA_W'(drop_prob_r);
      REG_AVG_WEIGHT: prdata = CFG_DATA_W'(avg_weight_r);
    endcase
  end

  // Handshakes.
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.average_len = out_avg_r;
  assign out_ch.drop        = out_drop_r;

  always_comb begin
    logic [LEN_W-1:0]  a_v;
    logic [AVG_W:0]    sum_v;
    logic [AVG_W:0]    even_v;
    logic [PROD_W-1:0] scaled_t_v;

    a_v        = avg_r[AVG_W-1:AVG_W-LEN_W];
    sum_v      = {1'b0, part_r} + mul_rsp.prod[AVG_W:0];
    even_v     = sum_v + (AVG_W+1)'(sum_v[0]);
    // t * 51200 as t * (2^15 + 2^14 + 2^11).
    scaled_t_v = (PROD_W'(t_r) << 15) + (PROD_W'(t_r) << 14) + (PROD_W'(t_r) << 11);

    state_nxt     = state_r;
    avg_nxt       = avg_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    sample_nxt    = sample_r;
    rnd_nxt       = rnd_r;
    part_nxt      = part_r;
    t_nxt         = t_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_avg_nxt   = out_avg_r;
    out_drop_nxt  = out_drop_r;
    mul_req       = '0;
    div_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.command;
          sample_nxt = in_ch.sample_len;
          rnd_nxt    = in_ch.random_value;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        drop_nxt = 1'b0;
        if (cmd_r == CMD_UPDATE) begin
          // A weight of 256 or more or an empty average loads the sample directly.
          if (avg_weight_r[WGT_W-1] || (avg_r == '0)) begin
            avg_nxt   = {sample_r, 8'd0};
            state_nxt = S_DONE;
          end else begin
            mul_req.go     = 1'b1;
            mul_req.mcand  = avg_r;
            mul_req.mplier = MPLIER_W'(WGT_RST - {1'b0, avg_weight_r[WGT_W-2:0]});
            mul_req.nbits  = NBITS_W'(WGT_W);
            state_nxt      = S_UPD_M1;
          end
        end else begin
          if (a_v <= thr_low_r) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (a_v > thr_high_r) begin
            drop_nxt  = 1'b1;
            count_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            mul_req.go     = 1'b1;
            mul_req.mcand  = MCAND_W'(a_v - thr_low_r);
            mul_req.mplier = MPLIER_W'(drop_prob_r);
            mul_req.nbits  = NBITS_W'(PROB_W);
            state_nxt      = S_CHK_M1;
          end
        end
      end

      S_UPD_M1: begin
        if (mul_rsp.done) begin
          part_nxt       = mul_rsp.prod[PROD_W-1:PROD_W-AVG_W];
          mul_req.go     = 1'b1;
          mul_req.mcand  = MCAND_W'(sample_r);
          mul_req.mplier = MPLIER_W'(avg_weight_r[WGT_W-2:0]);
          mul_req.nbits  = NBITS_W'(WGT_W - 1);
          state_nxt      = S_UPD_M2;
        end
      end

      S_UPD_M2: begin
        if (mul_rsp.done) begin
          // An odd sum is rounded up to the next even value.
          avg_nxt   = even_v[AVG_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_CHK_M1: begin
        if (mul_rsp.done) begin
          // The quotient stays below 2^16, so the divider runs in half mode.
          div_req.go   = 1'b1;
          div_req.num  = {mul_rsp.prod[PROD_W-10:0], 9'd0};
          div_req.den  = thr_high_r - thr_low_r;
          div_req.half = 1'b1;
          state_nxt    = S_CHK_D1;
        end
      end

      S_CHK_D1: begin
        if (div_rsp.done) begin
          t_nxt          = div_rsp.quot[LEN_W-1:0];
          mul_req.go     = 1'b1;
          mul_req.mcand  = MCAND_W'(div_rsp.quot[LEN_W-1:0]);
          mul_req.mplier = count_r;
          mul_req.nbits  = NBITS_W'(CNT_W);
          state_nxt      = S_CHK_M2;
        end
      end

      S_CHK_M2: begin
        if (mul_rsp.done) begin
          if (mul_rsp.prod >= PROD_W'(PROB_FULL)) begin
            drop_nxt  = 1'b1;
            count_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            div_req.go   = 1'b1;
            div_req.num  = scaled_t_v;
            div_req.den  = PROB_FULL - mul_rsp.prod[DEN_W-1:0];
            div_req.half = 1'b0;
            state_nxt    = S_CHK_D2;
          end
        end
      end

      S_CHK_D2: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > QUOT_W'(rnd_r)) begin
            drop_nxt  = 1'b1;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free or drains.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r[AVG_W-1:AVG_W-LEN_W];
          out_drop_nxt  = drop_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avg_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sample_r   <= sample_nxt;
    rnd_r      <= rnd_nxt;
    part_r     <= part_nxt;
    t_r        <= t_nxt;
    drop_r     <= drop_nxt;
    out_avg_r  <= out_avg_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // An accepted transaction always moves the sequencer into decode, and the
  // arithmetic units only report completion while the sequencer waits on them.
  `include "random_early_detection_top_assert.svh"

  `RED_ASSERT_NEXT(a_accept_decode, in_ch.valid && in_ch.ready, state_r == S_DECODE)
  `RED_ASSERT_IMPL(a_mul_done_state, mul_rsp.done,
                   state_r == S_UPD_M1 || state_r == S_UPD_M2 ||
                   state_r == S_CHK_M1 || state_r == S_CHK_M2)
  `RED_ASSERT_IMPL(a_div_done_state, div_rsp.done, state_r == S_CHK_D1 || state_r == S_CHK_D2)
  `RED_ASSERT_IMPL(a_update_no_drop, state_r == S_DONE && cmd_r == CMD_UPDATE, !drop_r)

endmodule

FILE: src/red_smul.sv
module red_smul (
  input  logic              clk,
  input  logic              rst_n,
  input  red_pkg::mul_req_t req,
  output red_pkg::mul_rsp_t rsp
);
  import red_pkg::*;

  // Shift-add multiplier, one multiplier bit per cycle.
  logic [PROD_W-1:0]   acc_r;
  logic [PROD_W-1:0]   mc_r;
  logic [MPLIER_W-1:0] mp_r;
  logic [NBITS_W-1:0]  cnt_r;
  logic                busy_r;
  logic                done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == NBITS_W'(1));
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - NBITS_W'(1);
        if (cnt_r == NBITS_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      acc_r <= '0;
      mc_r  <= PROD_W'(req.mcand);
      mp_r  <= req.mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: src/red_sdiv.sv
module red_sdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  red_pkg::div_req_t req,
  output red_pkg::div_rsp_t rsp
);
  import red_pkg::*;

  // Restoring divider, one quotient bit per cycle. In half mode the upper
  // half of the dividend is known to be below the divisor, so it is loaded
  // straight into the remainder and only the lower half is iterated.
  logic [DEN_W-1:0]     rem_r;
  logic [QUOT_W-1:0]    q_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DEN_W:0]   sh_v;
  logic [DEN_W:0]   diff_v;
  logic             ge_v;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    sh_v    = {rem_r, q_r[QUOT_W-1]};
    diff_v  = sh_v - {1'b0, den_r};
    ge_v    = (sh_v >= {1'b0, den_r});
    rem_nxt = ge_v ? diff_v[DEN_W-1:0] : sh_v[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.half ? DIV_CNT_W'(QUOT_W / 2) : DIV_CNT_W'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      den_r <= req.den;
      if (req.half) begin
        rem_r <= req.num[QUOT_W-1:QUOT_W/2];
        q_r   <= {req.num[QUOT_W/2-1:0], (QUOT_W/2)'(0)};
      end else begin
        rem_r <= '0;
        q_r   <= req.num;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QUOT_W-2:0], ge_v};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

FILE: tb/sv/random_early_detection_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the RED queue manager. A bit-accurate predictor of
// the running average and the undropped count runs alongside the block and
// is advanced once per accepted input transaction. The checker compares each
// output transaction, field by field, with the oldest prediction.
module random_early_detection_top_tb;
  import red_pkg::*;

  // The average is held scaled by 256; the drop probability uses 512 steps
  // per percent.
  localparam longint unsigned AVG_SCALE = 256;
  localparam longint unsigned PROB_STEP = 512;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 125;
  // The slowest item is a check between the thresholds, which passes through
  // every multiplier and divider pass before it reaches the output register.
  // The limit leaves room for that item plus long receiver stalls and sender gaps.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int MAX_REPORTS     = 40;

  typedef struct packed {
    logic [LEN_W-1:0] average_len;
    logic             drop;
  } red_decision_t;

  // How the receiver behaves over its current stretch of cycles.
  typedef enum int {RX_STREAM, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_mode_t;

  // Families of register settings used by the random phases.
  typedef enum int {SET_EXTREME, SET_ODD, SET_TANGLED, SET_TYPICAL} setting_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  red_in_if  in_ch();
  red_out_if out_ch();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  random_early_detection_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the register copies start at their reset defaults.
  logic [LEN_W-1:0]  cfg_thr_low  = THR_LOW_RST;
  logic [LEN_W-1:0]  cfg_thr_high = THR_HIGH_RST;
  logic [PROB_W-1:0] cfg_max_prob = PROB_RST;
  logic [WGT_W-1:0]  cfg_weight   = WGT_RST;
  logic [AVG_W-1:0]  red_avg      = '0;
  logic [CNT_W-1:0]  red_undropped = '0;

  // Predicted results in the order in which the block must return them.
  red_decision_t expected_decisions[$];
  red_decision_t oldest_decision;

  int mismatch_count = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;

  // Coverage tallies for the closing summary.
  int n_updates = 0;
  int n_checks = 0;
  int n_settings = 0;
  int n_below = 0;
  int n_above = 0;
  int n_forced = 0;
  int n_dice = 0;
  int n_kept = 0;

  // Advances the predicted block state by one command and returns the result
  // that the block has to produce for it.
  function automatic red_decision_t predict_red_decision(logic cmd,
                                                         logic [LEN_W-1:0] sample,
                                                         logic [LEN_W-1:0] rnd);
    longint unsigned wgt, sum, lvl, lo, hi, t, c, p;
    red_decision_t res;
    res.drop = 1'b0;
    if (cmd == CMD_UPDATE) begin
      n_updates++;
      // Weights above 256 act as 256, which loads the sample directly.
      wgt = 64'(cfg_weight);
      if (wgt > AVG_SCALE) begin
        wgt = AVG_SCALE;
      end
      if (wgt == AVG_SCALE || red_avg == '0) begin
        red_avg = {sample, 8'h00};
      end else begin
        sum = (AVG_SCALE - wgt) * 64'(red_avg) / AVG_SCALE + wgt * 64'(sample);
        // An odd weighted sum is always rounded up to an even value.
        if ((sum & 64'd1) != 0) begin
          sum = sum + 1;
        end
        red_avg = AVG_W'(sum);
      end
    end else begin
      n_checks++;
      lvl = 64'(red_avg[AVG_W-1:8]);
      lo  = 64'(cfg_thr_low);
      hi  = 64'(cfg_thr_high);
      // The low test wins when the thresholds are equal or inverted, so the
      // middle branch below always has a non-zero divisor.
      if (lvl <= lo) begin
        red_undropped = '0;
        n_below++;
      end else if (lvl > hi) begin
        res.drop = 1'b1;
        red_undropped = '0;
        n_above++;
      end else begin
        t = 64'(cfg_max_prob) * PROB_STEP * (lvl - lo) / (hi - lo);
        c = 64'(red_undropped) * t;
        if (c >= 64'(PROB_FULL)) begin
          res.drop = 1'b1;
          red_undropped = '0;
          n_forced++;
        end else begin
          p = t * 64'(PROB_FULL) / (64'(PROB_FULL) - c);
          if (p > 64'(rnd)) begin
            res.drop = 1'b1;
            red_undropped = '0;
            n_dice++;
          end else begin
            red_undropped = red_undropped + 1'b1;
            n_kept++;
          end
        end
      end
    end
    res.average_len = red_avg[AVG_W-1:8];
    return res;
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Sends one command. The sender runs in bursts; when a burst is used up it
  // may drop valid for a random gap before starting the next one. Valid is
  // left high after acceptance so that back-to-back transactions need no
  // extra assignment.
  task automatic send_item(logic cmd, logic [LEN_W-1:0] sample, logic [LEN_W-1:0] rnd);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.sample_len   <= sample;
    in_ch.random_value <= rnd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_decisions.push_back(predict_red_decision(cmd, sample, rnd));
  endtask

  // Holds the sender off until every predicted result has been returned.
  // At least one edge passes, so valid is never lowered and raised again in
  // the same time step.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_decisions.size() != 0);
  endtask

  // One APB write: a setup cycle, then an access cycle that completes at the
  // edge where pready is high. Back-to-back writes go straight to the next
  // setup cycle, so psel stays high between them.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_THR_LOW:    cfg_thr_low  = data[LEN_W-1:0];
      REG_THR_HIGH:   cfg_thr_high = data[LEN_W-1:0];
      REG_DROP_PROB:  cfg_max_prob = data[PROB_W-1:0];
      REG_AVG_WEIGHT: cfg_weight   = data[WGT_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only while the block is idle. Every command returns a
  // result, so an empty prediction store means nothing is in flight.
  task automatic set_config(logic [LEN_W-1:0] thr_lo, logic [LEN_W-1:0] thr_hi,
                            logic [PROB_W-1:0] prob, logic [WGT_W-1:0] wgt);
    pause_until_drained();
    write_reg(REG_THR_LOW, CFG_DATA_W'(thr_lo));
    write_reg(REG_THR_HIGH, CFG_DATA_W'(thr_hi));
    write_reg(REG_DROP_PROB, CFG_DATA_W'(prob));
    write_reg(REG_AVG_WEIGHT, CFG_DATA_W'(wgt));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  // Reset defaults: an empty average never drops, a one-packet middle band
  // drops on the dice, and a full queue lies above the high threshold.
  task automatic test_reset_defaults();
    send_item(CMD_CHECK, 16'd0, 16'd0);
    send_item(CMD_UPDATE, 16'd1, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
    send_item(CMD_UPDATE, 16'd65535, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd65535);
  endtask

  // Averaging: a zero average loads the sample even with a small weight, two
  // weighted updates follow, a zero weight freezes the average and a weight
  // above 256 loads the sample.
  task automatic test_weighted_average();
    send_item(CMD_UPDATE, 16'd0, 16'd0);
    set_config(16'd0, 16'd1, 7'd1, 9'd3);
    send_item(CMD_UPDATE, 16'd1234, 16'd65535);
    send_item(CMD_UPDATE, 16'd0, 16'd0);
    send_item(CMD_UPDATE, 16'd65535, 16'd0);
    set_config(16'd0, 16'd1, 7'd1, 9'd0);
    send_item(CMD_UPDATE, 16'd40000, 16'd0);
    set_config(16'd0, 16'd1, 7'd1, 9'd511);
    send_item(CMD_UPDATE, 16'd777, 16'd0);
  endtask

  // Threshold boundaries with the full probability: the average sitting on
  // the low threshold, on the high threshold (kept once, then dropped by the
  // count), in the middle, and one above the high threshold.
  task automatic test_threshold_edges();
    set_config(16'd100, 16'd200, 7'd100, 9'd256);
    send_item(CMD_UPDATE, 16'd100, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
    send_item(CMD_UPDATE, 16'd200, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd65535);
    send_item(CMD_CHECK, 16'd0, 16'd65535);
    send_item(CMD_UPDATE, 16'd150, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd51199);
    send_item(CMD_CHECK, 16'd0, 16'd51199);
    send_item(CMD_UPDATE, 16'd201, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
  endtask

  // Settings that software should not use: zero probability, probability
  // above 100 and inverted thresholds.
  task automatic test_odd_settings();
    set_config(16'd100, 16'd200, 7'd0, 9'd256);
    send_item(CMD_UPDATE, 16'd150, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
    set_config(16'd500, 16'd100, 7'd127, 9'd256);
    send_item(CMD_UPDATE, 16'd300, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
    send_item(CMD_UPDATE, 16'd600, 16'd0);
    send_item(CMD_CHECK, 16'd0, 16'd0);
  endtask

  // Random phases, each under a fresh register setting. Most samples land
  // around the thresholds so that the average spends time in the middle
  // band and the undropped count builds up; the rest is full-range noise.
  task automatic test_random_traffic();
    setting_kind_t kind;
    logic [LEN_W-1:0]  thr_lo, thr_hi, sample, rnd;
    logic [PROB_W-1:0] prob;
    logic [WGT_W-1:0]  wgt;
    logic              cmd;
    int                lo, hi, span, v;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        kind = setting_kind_t'(phase);
      end else if ($urandom_range(0, 3) == 0) begin
        kind = setting_kind_t'($urandom_range(0, 2));
      end else begin
        kind = SET_TYPICAL;
      end
      thr_lo = LEN_W'($urandom_range(0, 60000));
      case ($urandom_range(0, 2))
        0: span = $urandom_range(1, 40);
        1: span = $urandom_range(41, 3000);
        default: span = $urandom_range(3001, 65535);
      endcase
      thr_hi = (thr_lo + span > 65535) ? 16'd65535 : LEN_W'(thr_lo + span);
      prob = PROB_W'($urandom_range(1, 100));
      case ($urandom_range(0, 3))
        0: wgt = 9'd256;
        1: wgt = WGT_W'($urandom_range(1, 15));
        default: wgt = WGT_W'($urandom_range(16, 255));
      endcase
      case (kind)
        SET_EXTREME: begin
          thr_lo = 16'd0;
          thr_hi = 16'd65535;
          prob   = $urandom_range(0, 1) ? 7'd100 : 7'd127;
          wgt    = $urandom_range(0, 1) ? 9'd1 : 9'd256;
        end
        SET_ODD: begin
          prob = $urandom_range(0, 1) ? 7'd0 : PROB_W'($urandom_range(101, 127));
          wgt  = $urandom_range(0, 1) ? 9'd0 : WGT_W'($urandom_range(257, 511));
        end
        SET_TANGLED: begin
          thr_hi = $urandom_range(0, 1) ? thr_lo : LEN_W'($urandom_range(0, thr_lo));
        end
        default: ;
      endcase
      set_config(thr_lo, thr_hi, prob, wgt);

      lo = (thr_lo < thr_hi) ? int'(thr_lo) : int'(thr_hi);
      hi = (thr_lo < thr_hi) ? int'(thr_hi) : int'(thr_lo);
      span = hi - lo + 1;
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        cmd = ($urandom_range(0, 9) < 6) ? CMD_CHECK : CMD_UPDATE;
        if ($urandom_range(0, 9) == 0) begin
          sample = LEN_W'($urandom_range(0, 65535));
        end else begin
          v = lo - span / 2 + int'($urandom_range(0, 2 * span));
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          sample = LEN_W'(v);
        end
        case ($urandom_range(0, 19))
          0: rnd = LEN_W'($urandom_range(51200, 65535));
          1: rnd = LEN_W'($urandom_range(0, 255));
          default: rnd = LEN_W'($urandom_range(0, 51199));
        endcase
        send_item(cmd, sample, rnd);
        // Now and then the sender waits for the block to empty completely.
        if ($urandom_range(0, 79) == 0) begin
          pause_until_drained();
        end
      end
    end
  endtask

  // The receiver switches between stall patterns at random intervals:
  // streaming, mostly ready, seldom ready and a fixed periodic pattern.
  rx_mode_t rx_mode = RX_STREAM;
  int rx_span = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(16, 160);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      RX_STREAM:   out_ch.ready <= 1'b1;
      RX_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SELDOM:   out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:     out_ch.ready <= ((rx_tick % 8) < 3);
    endcase
  end

  // Each output transaction is matched against the oldest prediction. A
  // result arriving with nothing predicted is a failure of its own.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_decisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with none expected, actual average_len %0d drop %0d",
                   $time, out_ch.average_len, out_ch.drop);
        end
      end else begin
        oldest_decision = expected_decisions.pop_front();
        if (out_ch.average_len !== oldest_decision.average_len) begin
          note_mismatch("average_len", 32'(oldest_decision.average_len),
                        32'(out_ch.average_len));
        end
        if (out_ch.drop !== oldest_decision.drop) begin
          note_mismatch("drop", 32'(oldest_decision.drop), 32'(out_ch.drop));
        end
      end
    end
  end

  // The watchdog restarts on every transaction on either channel and on
  // every register access; a long silence means the block has hung.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_UPDATE;
    in_ch.sample_len   <= '0;
    in_ch.random_value <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    // Reset is applied once and released on a rising edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_weighted_average();
    test_threshold_edges();
    test_odd_settings();
    test_random_traffic();

    // Let the last results come back, then watch a while longer for strays.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d updates and %0d checks under %0d register settings.",
             n_updates, n_checks, n_settings);
    $display("Checks: %0d below low, %0d above high, %0d forced, %0d by dice, %0d kept.",
             n_below, n_above, n_forced, n_dice, n_kept);
    if (mismatch_count == 0 && expected_decisions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: random_early_detection_top.f
+incdir+src
src/red_pkg.sv
src/red_if.sv
src/red_smul.sv
src/red_sdiv.sv
src/random_early_detection_top.sv
tb/sv/random_early_detection_top_tb.sv
